### src/u2r_pkg.sv
// shared types, constants and functions of the uyvy to rgb24 stream converter
package u2r_pkg;

    localparam int unsigned Q_SHIFT  = 14;
    localparam int unsigned SUM_W    = 25;
    localparam int unsigned Q_DEPTH  = 2;
    localparam int unsigned QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned QCNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic signed [15:0] K_RV = 16'sd23061;
    localparam logic signed [15:0] K_GU = 16'sd5661;
    localparam logic signed [15:0] K_GV = 16'sd11746;
    localparam logic signed [15:0] K_BU = 16'sd19299;
    localparam logic signed [8:0]  CHROMA_MID = 9'sd128;
    localparam logic [7:0]         PIX_MAX = 8'd255;

    typedef enum logic [1:0] {
        PH_U  = 2'd0,
        PH_Y0 = 2'd1,
        PH_V  = 2'd2,
        PH_Y1 = 2'd3
    } t_phase;

    // one complete 4:2:2 group
    typedef struct packed {
        logic [7:0] u;
        logic [7:0] v;
        logic [7:0] y0;
        logic [7:0] y1;
    } t_group;

    typedef struct packed {
        logic   push;
        t_group group;
    } t_q_write;

    typedef struct packed {
        logic   valid;
        t_group group;
    } t_q_head;

    // floor shift by Q_SHIFT, then clamp to 0..255
    function automatic logic [7:0] scale_clamp(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-Q_SHIFT-1:0] q;
        logic [7:0]                      res;
        q = sum[SUM_W-1:Q_SHIFT];
        if (q[SUM_W-Q_SHIFT-1]) begin
            res = 8'd0;
        end else if (|q[SUM_W-Q_SHIFT-2:8]) begin
            res = PIX_MAX;
        end else begin
            res = q[7:0];
        end
        return res;
    endfunction

endpackage

### src/u2r_if.sv
// stream interfaces for the byte input and the pixel output
interface u2r_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       group_start;

    modport source (output valid, output data_byte, output group_start, input ready);
    modport sink   (input valid, input data_byte, input group_start, output ready);
endinterface

interface u2r_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pair_last;

    modport source (output valid, output red, output green, output blue, output pair_last,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input pair_last,
                    output ready);
endinterface

### src/uyvy_to_rgb24_stream_core.sv
// top level: uyvy byte stream in, rgb888 pixel pairs out
// the first pixel of a pair passes the group queue, the stage-1 register and the
//   output register after the Y1 byte transfer; the second follows unless the output stalls
// throughput: one byte per cycle while the queue is not full; the pixel pipeline
//   emits one pixel per cycle unless stalled; a 2-deep group queue absorbs stalls
// reset (synchronous, active low): byte phase expects U, queue and pipeline empty
module uyvy_to_rgb24_stream_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u2r_in_if.sink      i_in,
    u2r_out_if.source   o_out
);

    u2r_pkg::t_q_write w_q_wr;
    u2r_pkg::t_q_head  w_q_head;
    logic              w_q_full;
    logic              w_q_pop;

    u2r_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_q_full(w_q_full),
        .o_q_wr  (w_q_wr)
    );

    u2r_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_head  (w_q_head)
    );

    u2r_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_q_head),
        .o_pop   (w_q_pop),
        .o_out   (o_out)
    );

endmodule

### src/u2r_front.sv
// byte phase tracker that collects U, Y0, V, Y1 into groups
module u2r_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    u2r_in_if.sink              i_in,
    input  logic                i_q_full,
    output u2r_pkg::t_q_write   o_q_wr
);

    u2r_pkg::t_phase r_phase, n_phase;
    u2r_pkg::t_phase w_eff;
    logic [7:0]      r_u, r_y0, r_v;
    logic            w_acc;

    assign i_in.ready = !i_q_full;
    assign w_acc      = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= u2r_pkg::PH_U;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        w_eff   = i_in.group_start ? u2r_pkg::PH_U : r_phase;
        n_phase = r_phase;
        o_q_wr.push     = 1'b0;
        o_q_wr.group.u  = r_u;
        o_q_wr.group.v  = r_v;
        o_q_wr.group.y0 = r_y0;
        o_q_wr.group.y1 = i_in.data_byte;
        if (w_acc) begin
            case (w_eff)
                u2r_pkg::PH_U:  n_phase = u2r_pkg::PH_Y0;
                u2r_pkg::PH_Y0: n_phase = u2r_pkg::PH_V;
                u2r_pkg::PH_V:  n_phase = u2r_pkg::PH_Y1;
                u2r_pkg::PH_Y1: begin
                    n_phase     = u2r_pkg::PH_U;
                    o_q_wr.push = 1'b1;
                end
                default:        n_phase = u2r_pkg::PH_U;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            case (w_eff)
                u2r_pkg::PH_U:  r_u  <= i_in.data_byte;
                u2r_pkg::PH_Y0: r_y0 <= i_in.data_byte;
                u2r_pkg::PH_V:  r_v  <= i_in.data_byte;
                default: ;
            endcase
        end
    end

endmodule

### src/u2r_queue.sv
// short group queue between the byte front and the pixel back
module u2r_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u2r_pkg::t_q_write   i_wr,
    input  logic                i_pop,
    output logic                o_full,
    output u2r_pkg::t_q_head    o_head
);

    u2r_pkg::t_group                   r_mem [u2r_pkg::Q_DEPTH];
    logic [u2r_pkg::QPTR_W-1:0]        r_wr_ptr, r_rd_ptr;
    logic [u2r_pkg::QCNT_W-1:0]        r_count;
    logic                              w_pop;

    assign o_full       = (r_count == u2r_pkg::QCNT_W'(u2r_pkg::Q_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.group = r_mem[r_rd_ptr];
    assign w_pop        = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr_ptr <= (r_wr_ptr == u2r_pkg::QPTR_W'(u2r_pkg::Q_DEPTH - 1))
                            ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == u2r_pkg::QPTR_W'(u2r_pkg::Q_DEPTH - 1))
                            ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_wr.push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.group;
        end
    end

endmodule

### src/u2r_back.sv
// two-stage pixel pipeline: chroma products, then sums, shift and clamp
module u2r_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u2r_pkg::t_q_head    i_head,
    output logic                o_pop,
    u2r_out_if.source           o_out
);

    localparam int unsigned SW = u2r_pkg::SUM_W;

    logic                  w_en;
    logic                  w_take;
    logic                  r_pix;
    logic signed [8:0]     w_u, w_v;

    logic                  r_s1_valid;
    logic [7:0]            r_s1_y;
    logic                  r_s1_last;
    logic signed [SW-1:0]  r_s1_rv, r_s1_gu, r_s1_gv, r_s1_bu;
    logic signed [SW-1:0]  w_base, w_sum_r, w_sum_g, w_sum_b;

    logic                  r_out_valid;
    logic [7:0]            r_red, r_green, r_blue;
    logic                  r_last;

    // whole pipeline moves when the output register is free or being drained
    assign w_en   = !r_out_valid || o_out.ready;
    assign w_take = w_en && i_head.valid;
    assign o_pop  = w_take && r_pix;

    assign w_u = $signed({1'b0, i_head.group.u}) - u2r_pkg::CHROMA_MID;
    assign w_v = $signed({1'b0, i_head.group.v}) - u2r_pkg::CHROMA_MID;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= i_head.valid;
            r_out_valid <= r_s1_valid;
            if (i_head.valid) begin
                r_pix <= !r_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_s1_y    <= r_pix ? i_head.group.y1 : i_head.group.y0;
            r_s1_last <= r_pix;
            r_s1_rv   <= SW'(u2r_pkg::K_RV * w_v);
            r_s1_gu   <= SW'(u2r_pkg::K_GU * w_u);
            r_s1_gv   <= SW'(u2r_pkg::K_GV * w_v);
            r_s1_bu   <= SW'(u2r_pkg::K_BU * w_u);
        end
    end

    always_comb begin
        w_base  = $signed({{(SW - 8 - u2r_pkg::Q_SHIFT){1'b0}}, r_s1_y,
                           {u2r_pkg::Q_SHIFT{1'b0}}});
        w_sum_r = w_base + r_s1_rv;
        w_sum_g = w_base - r_s1_gu - r_s1_gv;
        w_sum_b = w_base + r_s1_bu;
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_s1_valid) begin
            r_red   <= u2r_pkg::scale_clamp(w_sum_r);
            r_green <= u2r_pkg::scale_clamp(w_sum_g);
            r_blue  <= u2r_pkg::scale_clamp(w_sum_b);
            r_last  <= r_s1_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.red       = r_red;
    assign o_out.green     = r_green;
    assign o_out.blue      = r_blue;
    assign o_out.pair_last = r_last;

endmodule
